// ===== rtl/core/bts_pkg.sv =====
// Shared types, constants and helpers of the bilinear texel sampler.
`timescale 1ns / 1ps

package bts_pkg;

    // Build-time limits
    localparam int MAX_DIM   = 256;
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int TEXEL_W   = 8;
    localparam int ADDR_W    = 16;
    localparam int COORD_W   = FRAC_BITS + 1;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = IDX_W + 1;
    localparam int ROW_W     = IDX_W + DIM_W;
    localparam int POS_W     = COORD_W + IDX_W;
    localparam int WGT_W     = 2 * FRAC_BITS + 1;
    localparam int PROD_W    = TEXEL_W + WGT_W;
    localparam int RES_W     = 16;
    localparam int RES_LSB   = 2 * FRAC_BITS - 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Input tdata layout, lowest field first
    localparam int TD_ADDR_LSB = 0;
    localparam int TD_VAL_LSB  = TD_ADDR_LSB + ADDR_W;
    localparam int TD_U_LSB    = TD_VAL_LSB + TEXEL_W;
    localparam int TD_V_LSB    = TD_U_LSB + COORD_W;
    localparam int TD_USED     = TD_V_LSB + COORD_W;
    localparam int S_TDATA_W   = ((TD_USED + 7) / 8) * 8;
    localparam int M_TDATA_W   = RES_W;

    // Storage and buffering
    localparam int STORE_DEPTH = 65536;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int CREDIT_W    = $clog2(OUT_DEPTH + 1);
    localparam int NUM_TAPS    = 4;
    localparam int TAP_W       = $clog2(NUM_TAPS);

    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_BITS;

    // Item kinds on tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // One classified item between front and back. Taps are ordered
    // (x,y), (x+1,y), (x,y+1), (x+1,y+1); a write uses tap 0 as its address.
    typedef struct packed {
        logic                             sample;
        logic [NUM_TAPS-1:0][ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0]               value;
        logic [FRAC_BITS-1:0]             du;
        logic [FRAC_BITS-1:0]             dv;
    } bts_entry_t;

    // Back-end occupancy seen by the top level
    typedef struct packed {
        logic [CREDIT_W-1:0] credit;
        logic [CREDIT_W-1:0] out_count;
    } bts_back_stat_t;

    // Last usable index of a dimension; 0 acts as 1, above MAX_DIM as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0)
        begin
            r = '0;
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(d - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bts_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write or read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bts_front.sv =====
// Front end: accepts items, scales coordinates and forms the four tap addresses.
`timescale 1ns / 1ps

module bts_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bts_pkg::S_TDATA_W-1:0]  s_tdata,   // texel_address, texel_value, u_coord, v_coord
    input  logic                           s_tuser,   // op
    input  logic [bts_pkg::IDX_W-1:0]      x_last,
    input  logic [bts_pkg::IDX_W-1:0]      y_last,
    output logic                           q_push,
    output bts_pkg::bts_entry_t            q_data,
    input  logic                           q_full
);

    import bts_pkg::*;

    logic                 adv;

    // Stage 0: captured item
    logic                 s0_vld_reg;
    logic                 s0_op_reg;
    logic [ADDR_W-1:0]    s0_addr_reg;
    logic [TEXEL_W-1:0]   s0_val_reg;
    logic [COORD_W-1:0]   s0_u_reg;
    logic [COORD_W-1:0]   s0_v_reg;
    logic [COORD_W-1:0]   u_in;
    logic [COORD_W-1:0]   v_in;

    // Stage 1: scaled positions
    logic                 s1_vld_reg;
    logic                 s1_op_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [TEXEL_W-1:0]   s1_val_reg;
    logic [POS_W-1:0]     s1_pu_reg;
    logic [POS_W-1:0]     s1_pv_reg;

    // Stage 2: classified entry
    logic                 s2_vld_reg;
    bts_entry_t           s2_reg;
    bts_entry_t           s2_next;

    logic [IDX_W-1:0]     iu;
    logic [IDX_W-1:0]     iv;
    logic [IDX_W-1:0]     iu1;
    logic [IDX_W-1:0]     iv1;
    logic [DIM_W-1:0]     row_len;
    logic [ROW_W-1:0]     row0;
    logic [ROW_W-1:0]     row1;

    // Whole pipe moves unless the finished entry cannot enter the queue
    assign adv      = !s2_vld_reg || !q_full;
    assign s_tready = adv;
    assign q_push   = s2_vld_reg && !q_full;
    assign q_data   = s2_reg;

    // Coordinates above one saturate
    always_comb
    begin
        u_in = s_tdata[TD_U_LSB +: COORD_W];
        v_in = s_tdata[TD_V_LSB +: COORD_W];
        if (u_in > COORD_ONE)
        begin
            u_in = COORD_ONE;
        end
        if (v_in > COORD_ONE)
        begin
            v_in = COORD_ONE;
        end
    end

    // Index, clamped neighbor and row base addresses
    always_comb
    begin
        iu      = s1_pu_reg[FRAC_BITS +: IDX_W];
        iv      = s1_pv_reg[FRAC_BITS +: IDX_W];
        iu1     = (iu < x_last) ? iu + IDX_W'(1) : x_last;
        iv1     = (iv < y_last) ? iv + IDX_W'(1) : y_last;
        row_len = DIM_W'(x_last) + DIM_W'(1);
        row0    = ROW_W'(iv) * ROW_W'(row_len);
        row1    = ROW_W'(iv1) * ROW_W'(row_len);

        s2_next.sample  = s1_op_reg;
        s2_next.value   = s1_val_reg;
        s2_next.du      = s1_pu_reg[FRAC_BITS-1:0];
        s2_next.dv      = s1_pv_reg[FRAC_BITS-1:0];
        s2_next.addr[1] = ADDR_W'(row0 + ROW_W'(iu1));
        s2_next.addr[2] = ADDR_W'(row1 + ROW_W'(iu));
        s2_next.addr[3] = ADDR_W'(row1 + ROW_W'(iu1));
        if (s1_op_reg == OP_SAMPLE)
        begin
            s2_next.addr[0] = ADDR_W'(row0 + ROW_W'(iu));
        end
        else
        begin
            s2_next.addr[0] = s1_addr_reg;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= s_tvalid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg   <= s_tuser;
            s0_addr_reg <= s_tdata[TD_ADDR_LSB +: ADDR_W];
            s0_val_reg  <= s_tdata[TD_VAL_LSB +: TEXEL_W];
            s0_u_reg    <= u_in;
            s0_v_reg    <= v_in;

            s1_op_reg   <= s0_op_reg;
            s1_addr_reg <= s0_addr_reg;
            s1_val_reg  <= s0_val_reg;
            s1_pu_reg   <= POS_W'(s0_u_reg) * POS_W'(x_last);
            s1_pv_reg   <= POS_W'(s0_v_reg) * POS_W'(y_last);

            s2_reg      <= s2_next;
        end
    end

endmodule

// ===== rtl/core/bts_queue.sv =====
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module bts_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bts_pkg::bts_entry_t         push_data,
    output logic                        full,
    input  logic                        pop,
    output logic                        valid,
    output bts_pkg::bts_entry_t         head,
    output logic [bts_pkg::QCNT_W-1:0]  count
);

    import bts_pkg::*;

    bts_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/bts_back.sv =====
// Back end: texel writes, four-tap fetch, bilinear blend and result buffer.
`timescale 1ns / 1ps

module bts_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  bts_pkg::bts_entry_t            q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bts_pkg::M_TDATA_W-1:0]  m_tdata,   // sample_value
    output bts_pkg::bts_back_stat_t        stat
);

    import bts_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [TAP_W-1:0]       tap_reg;
    logic [TAP_W-1:0]       tap_next;
    bts_entry_t             cur_reg;

    logic                   room;
    logic                   start;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [TEXEL_W-1:0]     ram_rdata;

    // Blend pipeline
    logic                   fetch;
    logic [COORD_W-1:0]     fx;
    logic [COORD_W-1:0]     fy;
    logic                   rd_vld_reg;
    logic                   rd_first_reg;
    logic                   rd_last_reg;
    logic [WGT_W-1:0]       wgt_reg;
    logic                   p_vld_reg;
    logic                   p_first_reg;
    logic                   p_last_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [PROD_W-1:0]      acc_next;

    // Result buffer and credits
    logic [RES_W-1:0]       ob_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]      ob_wr_reg;
    logic [OPTR_W-1:0]      ob_rd_reg;
    logic [CREDIT_W-1:0]    ob_cnt_reg;
    logic [CREDIT_W-1:0]    credit_reg;
    logic                   ob_push;
    logic                   ob_pop;

    assign room  = (credit_reg < CREDIT_W'(OUT_DEPTH));
    assign fetch = (state_reg == ST_FETCH);

    // Sequencer: writes go to the RAM only in idle; a sample holds it for its taps
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        start      = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = q_head.addr[0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !q_head.sample)
                begin
                    ram_we = 1'b1;
                end
                else if (q_valid && room)
                begin
                    start      = 1'b1;
                    state_next = ST_FETCH;
                    tap_next   = '0;
                end
            end
            ST_FETCH:
            begin
                ram_addr = cur_reg.addr[tap_reg];
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(NUM_TAPS - 1))
                begin
                    if (q_valid && q_head.sample && room)
                    begin
                        start    = 1'b1;
                        tap_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign q_pop = ram_we || start;

    bts_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_head.value),
        .rdata (ram_rdata)
    );

    // Weight factors: tap bit 0 picks du over 1-du, bit 1 dv over 1-dv
    always_comb
    begin
        if (tap_reg[0])
        begin
            fx = COORD_W'(cur_reg.du);
        end
        else
        begin
            fx = COORD_ONE - COORD_W'(cur_reg.du);
        end
        if (tap_reg[1])
        begin
            fy = COORD_W'(cur_reg.dv);
        end
        else
        begin
            fy = COORD_ONE - COORD_W'(cur_reg.dv);
        end
    end

    assign acc_next = (p_first_reg ? '0 : acc_reg) + prod_reg;
    assign ob_push  = p_vld_reg && p_last_reg;
    assign ob_pop   = m_tvalid && m_tready;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tap_reg    <= '0;
            rd_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
            ob_wr_reg  <= '0;
            ob_rd_reg  <= '0;
            ob_cnt_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tap_reg    <= tap_next;
            rd_vld_reg <= fetch;
            p_vld_reg  <= rd_vld_reg;
            if (ob_push)
            begin
                ob_wr_reg <= ob_wr_reg + OPTR_W'(1);
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ob_rd_reg + OPTR_W'(1);
            end
            ob_cnt_reg <= ob_cnt_reg + CREDIT_W'(ob_push) - CREDIT_W'(ob_pop);
            credit_reg <= credit_reg + CREDIT_W'(start) - CREDIT_W'(ob_pop);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= q_head;
        end
        rd_first_reg <= (tap_reg == '0);
        rd_last_reg  <= (tap_reg == TAP_W'(NUM_TAPS - 1));
        wgt_reg      <= WGT_W'(fx) * WGT_W'(fy);
        p_first_reg  <= rd_first_reg;
        p_last_reg   <= rd_last_reg;
        prod_reg     <= PROD_W'(ram_rdata) * PROD_W'(wgt_reg);
        if (p_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= acc_next[RES_LSB +: RES_W];
        end
    end

    assign m_tvalid         = (ob_cnt_reg != '0);
    assign m_tdata          = ob_reg[ob_rd_reg];
    assign stat.credit      = credit_reg;
    assign stat.out_count   = ob_cnt_reg;

endmodule

// ===== rtl/core/bilinear_texel_sampler.sv =====
// Top level of the bilinear texel sampler: configuration, front, queue and back.
`timescale 1ns / 1ps

// Single-channel 8-bit image of up to 256x256 texels with bilinear sampling.
// A write item (tuser 0) stores one texel at its row-major address and gives
// no result; a sample item (tuser 1) gives one Q8.8 result from unsigned Q1.16
// u and v, which saturate at 1.0. The front is a three-stage pipeline that
// takes an item every cycle while the item queue has room; the back owns the
// single-port 64K x 8 image RAM. A write uses the RAM for a single access, a
// sample for four texel fetches, one per cycle. Writes go one per clock while
// no sample is fetching; a sample may start on the last fetch of the one
// before. Results are buffered two deep, so input keeps flowing while a
// result waits. The image RAM has no clearing pass: only written texels may
// be sampled. Change image_width and image_height only while the block is idle.
module bilinear_texel_sampler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bts_pkg::S_TDATA_W-1:0]  s_tdata,   // texel_address[15:0], texel_value[23:16],
                                                      // u_coord[40:24], v_coord[57:41], zero pad
    input  logic                           s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bts_pkg::M_TDATA_W-1:0]  m_tdata    // sample_value
);

    import bts_pkg::*;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [IDX_W-1:0]   x_last;
    logic [IDX_W-1:0]   y_last;

    logic               q_push;
    bts_entry_t         q_data;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    bts_entry_t         q_head;
    logic [QCNT_W-1:0]  q_count;
    bts_back_stat_t     back_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign x_last = dim_last(width_reg);
    assign y_last = dim_last(height_reg);

    bts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .x_last   (x_last),
        .y_last   (y_last),
        .q_push   (q_push),
        .q_data   (q_data),
        .q_full   (q_full)
    );

    bts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head),
        .count     (q_count)
    );

    bts_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (back_stat)
    );

    // Queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("item queue over depth");

    // Front only stalls on a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (q_count == QCNT_W'(QUEUE_DEPTH)))
        else $error("input stalled with room in queue");

    // Results in the buffer never exceed issued credits, and credits stay bounded
    a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.out_count <= back_stat.credit) &&
        (back_stat.credit <= CREDIT_W'(OUT_DEPTH)))
        else $error("result buffer out of step with credits");

    // A shown result always belongs to a started sample
    a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (back_stat.credit != '0))
        else $error("result shown without a sample in flight");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the bilinear texel sampler.
`timescale 1ns / 1ps

module tb_top;

    import bts_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int LONG_HOLD  = 200;
    localparam int SETTLE     = 30;

    // Four tap addresses in (x,y), (x+1,y), (x,y+1), (x+1,y+1) order plus fractions
    typedef struct {
        logic [ADDR_W-1:0]    addr [NUM_TAPS];
        logic [FRAC_BITS-1:0] du;
        logic [FRAC_BITS-1:0] dv;
    } tap_set_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // texel_address, texel_value, u_coord, v_coord, zero pad
    logic                   s_tuser;   // op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // sample_value

    // Mirror of the image and the size registers
    logic [TEXEL_W-1:0]     texel_mirror [STORE_DEPTH];
    bit                     texel_written [STORE_DEPTH];
    logic [CFG_W-1:0]       cols_reg;
    logic [CFG_W-1:0]       rows_reg;

    logic [RES_W-1:0]       sample_q [$];
    int                     err_count;
    int                     idle_pct;
    bit                     hold_req;
    logic [ADDR_W-1:0]      recent_addr [NUM_TAPS];

    bilinear_texel_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Hard limit on run time
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Size in use: 0 acts as 1, above MAX_DIM as MAX_DIM
    function automatic int dim_in_use(input logic [CFG_W-1:0] d);
        int r;
        r = int'(d);
        if (r < 1)
        begin
            r = 1;
        end
        else if (r > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    // Integer positions, clamped neighbors and fractions of one sample
    function automatic tap_set_t locate_taps(input logic [COORD_W-1:0] u,
                                             input logic [COORD_W-1:0] v);
        tap_set_t t;
        int w;
        int h;
        int pu;
        int pv;
        int x0;
        int y0;
        int x1;
        int y1;
        w = dim_in_use(cols_reg);
        h = dim_in_use(rows_reg);
        pu = int'((u > COORD_ONE) ? COORD_ONE : u) * (w - 1);
        pv = int'((v > COORD_ONE) ? COORD_ONE : v) * (h - 1);
        x0 = pu >> FRAC_BITS;
        y0 = pv >> FRAC_BITS;
        x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
        t.du = FRAC_BITS'(pu);
        t.dv = FRAC_BITS'(pv);
        t.addr[0] = ADDR_W'(y0 * w + x0);
        t.addr[1] = ADDR_W'(y0 * w + x1);
        t.addr[2] = ADDR_W'(y1 * w + x0);
        t.addr[3] = ADDR_W'(y1 * w + x1);
        return t;
    endfunction

    // Exact bilinear blend, truncated to Q8.8
    function automatic logic [RES_W-1:0] blend_taps(input tap_set_t t);
        logic [63:0] du;
        logic [63:0] dv;
        logic [63:0] ndu;
        logic [63:0] ndv;
        logic [63:0] acc;
        du  = 64'(t.du);
        dv  = 64'(t.dv);
        ndu = 64'(COORD_ONE) - du;
        ndv = 64'(COORD_ONE) - dv;
        acc = 64'(texel_mirror[t.addr[0]]) * (ndu * ndv)
            + 64'(texel_mirror[t.addr[1]]) * (du * ndv)
            + 64'(texel_mirror[t.addr[2]]) * (ndu * dv)
            + 64'(texel_mirror[t.addr[3]]) * (du * dv);
        return RES_W'(acc >> RES_LSB);
    endfunction

    // Coordinates weighted toward zero, one and saturation
    function automatic logic [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return '0;
        end
        else if (r < 16)
        begin
            return COORD_ONE;
        end
        else if (r < 26)
        begin
            return COORD_W'($urandom_range(2 ** COORD_W - 1, int'(COORD_ONE) + 1));
        end
        return COORD_W'($urandom_range(int'(COORD_ONE)));
    endfunction

    // Send one item; the mirror is updated when it is accepted
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [TEXEL_W-1:0] value,
                             input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({v, u, value, addr});
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (op == OP_WRITE)
        begin
            texel_mirror[addr]  = value;
            texel_written[addr] = 1'b1;
        end
        else
        begin
            sample_q.push_back(blend_taps(locate_taps(u, v)));
        end
        @(negedge clk);
    endtask

    task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [TEXEL_W-1:0] value);
        send_item(OP_WRITE, addr, value, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        send_item(OP_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), u, v);
    endtask

    // Drop valid, wait for all results and for in-flight writes to drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
        begin
            cols_reg = data;
        end
        else
        begin
            rows_reg = data;
        end
    endtask

    task automatic set_image_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, cols);
        write_reg(REG_IMAGE_HEIGHT, rows);
    endtask

    // Random samples; taps never written are filled first, plus stray writes
    task automatic run_sample_stream(input int n_items);
        int sent;
        int r;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        tap_set_t taps;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                write_texel(ADDR_W'($urandom), TEXEL_W'($urandom));
                sent++;
            end
            else if (r < 18)
            begin
                // overwrite a texel just read by the last sample
                write_texel(recent_addr[$urandom_range(NUM_TAPS - 1)], TEXEL_W'($urandom));
                sent++;
            end
            else
            begin
                u = rand_coord();
                v = rand_coord();
                taps = locate_taps(u, v);
                for (int k = 0; k < NUM_TAPS; k++)
                begin
                    if (!texel_written[taps.addr[k]])
                    begin
                        write_texel(taps.addr[k], TEXEL_W'($urandom));
                        sent++;
                    end
                end
                sample_at(u, v);
                recent_addr = taps.addr;
                sent++;
            end
        end
    endtask

    // Size registers at reset value: a 1x1 image
    task automatic test_reset_size();
        write_texel('0, 8'hA5);
        sample_at('0, '0);
        sample_at(COORD_ONE, COORD_ONE);
        sample_at('1, '1);
    endtask

    // 2x2 image: corners, center, saturation, extreme values and addresses
    task automatic test_corners();
        set_image_size(CFG_W'(2), CFG_W'(2));
        write_texel(ADDR_W'(0), 8'h00);
        write_texel(ADDR_W'(1), 8'hFF);
        write_texel(ADDR_W'(2), 8'h80);
        write_texel(ADDR_W'(3), 8'h01);
        write_texel('1, 8'hFF);
        sample_at('0, '0);
        sample_at(COORD_ONE, '0);
        sample_at('0, COORD_ONE);
        sample_at(COORD_ONE, COORD_ONE);
        sample_at(COORD_ONE >> 1, COORD_ONE >> 1);
        sample_at(COORD_ONE - 1, COORD_W'(1));
        sample_at(COORD_W'(1), COORD_ONE - 1);
        sample_at('1, '0);
        write_texel(ADDR_W'(3), 8'hC8);
        sample_at(COORD_ONE, COORD_ONE);
    endtask

    // Random streams over several sizes, out-of-range register values among them
    task automatic test_random_sizes();
        set_image_size(CFG_W'(256), CFG_W'(256));
        idle_pct = 30;
        run_sample_stream(300);
        set_image_size(CFG_W'(3), CFG_W'(5));
        idle_pct = 50;
        run_sample_stream(200);
        set_image_size(CFG_W'(1), CFG_W'(256));
        idle_pct = 0;
        run_sample_stream(150);
        set_image_size(CFG_W'(256), CFG_W'(1));
        idle_pct = 30;
        run_sample_stream(150);
        set_image_size(CFG_W'(0), CFG_W'(7));
        idle_pct = 50;
        run_sample_stream(100);
        set_image_size('1, CFG_W'(2));
        idle_pct = 30;
        run_sample_stream(100);
        set_image_size(CFG_W'(17), '0);
        idle_pct = 0;
        run_sample_stream(100);
        set_image_size(CFG_W'(17), CFG_W'(9));
        idle_pct = 50;
        run_sample_stream(150);
    endtask

    // Results held back long enough for the input to stall
    task automatic test_output_stall();
        set_image_size(CFG_W'(8), CFG_W'(8));
        idle_pct = 0;
        hold_req = 1'b1;
        run_sample_stream(120);
    endtask

    // Full rate on both sides to the end
    task automatic test_full_rate();
        set_image_size(CFG_W'(64), CFG_W'(32));
        idle_pct = 0;
        run_sample_stream(300);
    endtask

    // Result side: random stalls and the requested long hold
    initial
    begin
        int burst;
        burst = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                burst = LONG_HOLD;
            end
            else if (burst == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                burst = $urandom_range(4, 1);
            end
            if (burst > 0)
            begin
                m_tready <= 1'b0;
                burst--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result with the oldest expected sample
    initial
    begin
        logic [RES_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("sample_value: expected none, got %0d", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("sample_value: expected %0d, got %0d", want, m_tdata);
                        err_count++;
                    end
                end
            end
        end
    end

    // Reset, tests in turn, drain and verdict
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_WRITE;
        s_tdata   = '0;
        cols_reg  = CFG_W'(1);
        rows_reg  = CFG_W'(1);
        err_count = 0;
        idle_pct  = 0;
        hold_req  = 1'b0;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            recent_addr[k] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_size();
        test_corners();
        test_random_sizes();
        test_output_stall();
        test_full_rate();

        wait_idle();
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
